FILE: hw/rtl/nqr_pkg.sv
// Package for the numbered queue with removal.
// Holds the request/result types, mode and status codes, and the
// command struct between controller and datapath. No dependencies.
package nqr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int TAG_W     = 32;
    localparam int NUM_W     = 16;

    typedef enum logic [1:0] {
        MODE_ADMIT  = 2'd0,
        MODE_PEEK   = 2'd1,
        MODE_SERVE  = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_EMPTY      = 3'd1,
        STAT_NOT_PEEKED = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_NOT_FOUND  = 3'd4
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [TAG_W-1:0]   payload;
        logic [NUM_W-1:0]   number;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   payload_out;
        logic [NUM_W-1:0]   number_out;
    } t_res;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

FILE: hw/rtl/nqr_ctrl.sv
// Controller for the numbered queue: two-state one-hot sequencer that
// issues capture and execute commands. Depends on nqr_pkg.
module nqr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output nqr_pkg::t_cmd o_cmd
);
    import nqr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign busy          = (r_state == S_EXEC);

    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("capture not followed by execute");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_exec_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd.capture |=> !o_cmd.exec)
        else $error("execute without a captured request");

endmodule

FILE: hw/rtl/nqr_datapath.sv
// Datapath for the numbered queue: shift-register cells with parallel
// number match, gap compaction, counters and result register.
// Depends on nqr_pkg.
module nqr_datapath #(
    parameter int DEPTH = nqr_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nqr_pkg::t_cmd i_cmd,
    input  nqr_pkg::t_req i_req,
    output logic          o_strobe,
    output nqr_pkg::t_res o_res
);
    import nqr_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [TAG_W-1:0] r_tags [DEPTH];
    logic [TAG_W-1:0] n_tags [DEPTH];
    logic [NUM_W-1:0] r_nums [DEPTH];
    logic [NUM_W-1:0] n_nums [DEPTH];
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic             r_armed;
    logic             n_armed;
    logic [NUM_W-1:0] r_next;
    logic [NUM_W-1:0] n_next;
    t_req             r_req;
    logic [DEPTH-1:0] r_hit;
    logic [DEPTH-1:0] hit_cap;
    logic [DEPTH-1:0] hit_mask;
    logic [DEPTH-1:0] shift_en;
    t_res             r_res;
    t_res             n_res;
    logic             r_strobe;

    // match against live entries only
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit_cap[i] = (r_nums[i] == i_req.number) && (OCC_W'(i) < r_occ);
        end
    end

    // cells at or past the first hit move up
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit_mask[i] = |(r_hit << (DEPTH - 1 - i));
        end
    end

    always_comb begin
        n_tags   = r_tags;
        n_nums   = r_nums;
        n_occ    = r_occ;
        n_armed  = r_armed;
        n_next   = r_next;
        n_res    = '0;
        shift_en = '0;
        if (i_cmd.exec) begin
            unique case (r_req.mode)
                MODE_ADMIT: begin
                    if (r_occ == OCC_W'(DEPTH)) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        n_tags[r_occ[IDX_W-1:0]] = r_req.payload;
                        n_nums[r_occ[IDX_W-1:0]] = r_next;
                        n_res.number_out         = r_next;
                        n_occ                    = r_occ + 1'b1;
                        n_next                   = r_next + 1'b1;
                    end
                end
                MODE_PEEK: begin
                    if (r_occ == '0) begin
                        n_armed      = 1'b0;
                        n_res.status = STAT_EMPTY;
                    end else begin
                        n_armed           = 1'b1;
                        n_res.payload_out = r_tags[0];
                        n_res.number_out  = r_nums[0];
                    end
                end
                MODE_SERVE: begin
                    n_armed = 1'b0;
                    if (r_occ == '0) begin
                        n_res.status = STAT_EMPTY;
                    end else if (!r_armed) begin
                        n_res.status = STAT_NOT_PEEKED;
                    end else begin
                        shift_en = '1;
                        n_occ    = r_occ - 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (|r_hit) begin
                        shift_en = hit_mask;
                        n_occ    = r_occ - 1'b1;
                    end else begin
                        n_res.status = STAT_NOT_FOUND;
                    end
                end
            endcase
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (shift_en[i]) begin
                n_tags[i] = r_tags[i+1];
                n_nums[i] = r_nums[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tags <= n_tags;
        r_nums <= n_nums;
        r_res  <= n_res;
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_hit <= hit_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_armed  <= 1'b0;
            r_next   <= NUM_W'(1);
            r_strobe <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            r_armed  <= n_armed;
            r_next   <= n_next;
            r_strobe <= i_cmd.exec;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_occ <= OCC_W'(DEPTH)))
        else $error("occupancy above depth");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_occ == $past(r_occ) || r_occ == $past(r_occ) + 1'b1
                        || r_occ == $past(r_occ) - 1'b1))
        else $error("occupancy moved by more than one");

    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_occ) && $stable(r_next) && $stable(r_armed)))
        else $error("queue state changed without a request");

    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_strobe)
        else $error("missing result strobe");

endmodule

FILE: hw/rtl/numbered_queue_with_removal_core.sv
// Numbered queue with removal: top level joining nqr_ctrl and nqr_datapath.
// The result strobe is registered from execute and follows busy in the next cycle.
// A new request is taken only while not busy, as set by the capture/execute sequence.
// Remove searches all cells in parallel and compacts in the execute cycle.
// Synchronous active-low reset empties the queue, disarms peek, numbers from 1.
// Results cannot be stalled; o_strobe marks each for exactly one cycle.
module numbered_queue_with_removal_core #(
    parameter int DEPTH = nqr_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  nqr_pkg::t_req i_req,
    output logic          o_strobe,
    output nqr_pkg::t_res o_res
);
    import nqr_pkg::*;

    t_cmd cmd;

    nqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    nqr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
